[sv/keypad_scan_key_fifo_assert.svh]
// Assertion macros for the keypad scanner with key FIFO.
`ifndef KEYPAD_SCAN_KEY_FIFO_ASSERT_SVH
`define KEYPAD_SCAN_KEY_FIFO_ASSERT_SVH

// Implication checked at every rising clock edge outside reset.
`define KSF_ASSERT_IMP(lbl, clk_s, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Condition that must never be seen outside reset.
`define KSF_ASSERT_NEVER(lbl, clk_s, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) !(cond)) \
		else $error(msg);

`endif

[sv/ksf_pkg.sv]
// Shared types, constants and key map of the keypad scanner.
package ksf_pkg;

	// column counter covers the largest column count of eight
	localparam int COL_CNT_W = 3;
	localparam int LIMIT_W = 7;
	localparam int FILL_W = 9;
	localparam logic [LIMIT_W-1:0] MAX_READ = 7'd64;
	localparam int FILL_MAX = 511;
	localparam int MAP_ROWS = 4;
	localparam int MAP_COLS = 3;

	// request kinds carried in tuser
	localparam logic REQ_SCAN = 1'b0;
	localparam logic REQ_READ = 1'b1;

	localparam logic [7:0] KEY_MAP [MAP_ROWS*MAP_COLS] = '{
		"1", "2", "3",
		"4", "5", "6",
		"7", "8", "9",
		"*", "0", "#"
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SCAN_DONE,
		ST_RD_ADDR,
		ST_RD_DATA,
		ST_EMPTY
	} ksf_state_t;

	typedef struct packed {
		logic [7:0]        key_char;
		logic              char_valid;
		logic              last_item;
		logic [1:0]        keys_added;
		logic              overflow;
		logic [FILL_W-1:0] fill_level;
	} ksf_res_t;

	// keys outside the 4x3 map give code 0
	function automatic logic [7:0] key_code(input logic [1:0] row,
		input logic [COL_CNT_W-1:0] col);
		logic [7:0] code;
		code = 8'h00;
		if (col < COL_CNT_W'(MAP_COLS)) begin
			code = KEY_MAP[4'(row) * 4'(MAP_COLS) + 4'(col[1:0])];
		end
		return code;
	endfunction

endpackage

[sv/ksf_ring.sv]
// Character ring storage: one write port, one registered read port.
module ksf_ring #(
	parameter int DEPTH = 256,
	parameter int AW = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[sv/ksf_seq.sv]
// Sequencer: walks columns of a scan one per cycle, drains the ring one char per pass.
module ksf_seq #(
	parameter int RING_DEPTH = 256,
	parameter int ROW_COUNT = 4,
	parameter int COLUMN_COUNT = 3,
	parameter int AW = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         in_req,
	input  logic [1:0]                   in_row,
	input  logic [2:0]                   in_cols,
	input  logic [ksf_pkg::LIMIT_W-1:0]  in_limit,
	input  logic                         out_free,
	output logic                         push,
	output ksf_pkg::ksf_res_t            res,
	output logic                         mem_we,
	output logic [AW-1:0]                mem_waddr,
	output logic [7:0]                   mem_wdata,
	output logic                         mem_re,
	output logic [AW-1:0]                mem_raddr,
	input  logic [7:0]                   mem_rdata
);

	localparam int HW = $clog2(RING_DEPTH + 1);
	localparam int KN = ROW_COUNT * COLUMN_COUNT;
	localparam int KW = (KN > 1) ? $clog2(KN) : 1;
	localparam int CW = ksf_pkg::COL_CNT_W;

	ksf_pkg::ksf_state_t state_q, state_d;

	logic [KN-1:0]                key_q;
	logic [AW-1:0]                wr_q, rd_q;
	logic [HW-1:0]                held_q;
	logic [CW-1:0]                col_q;
	logic [KW-1:0]                idx_q;
	logic [1:0]                   row_q;
	logic [2:0]                   lvl_q;
	logic [1:0]                   added_q;
	logic                         ovf_q;
	logic [ksf_pkg::LIMIT_W-1:0]  remain_q;

	logic                         accept;
	logic                         row_ok;
	logic [ksf_pkg::LIMIT_W-1:0]  lim;
	logic [ksf_pkg::LIMIT_W-1:0]  n_rd;
	logic                         lvl;
	logic                         chg;
	logic                         rise;
	logic                         room;
	logic                         last_col;
	logic [ksf_pkg::FILL_W-1:0]   fill;

	assign accept = in_valid && in_ready;
	assign row_ok = int'(in_row) < ROW_COUNT;

	always_comb begin
		lim = (in_limit > ksf_pkg::MAX_READ) ? ksf_pkg::MAX_READ : in_limit;
		if (int'(held_q) < int'(lim)) begin
			n_rd = ksf_pkg::LIMIT_W'(held_q);
		end else begin
			n_rd = lim;
		end
	end

	// current column of the scan
	assign lvl      = (col_q < CW'(3)) ? lvl_q[col_q[1:0]] : 1'b0;
	assign chg      = key_q[idx_q] != lvl;
	assign rise     = chg && lvl;
	assign room     = int'(held_q) < RING_DEPTH;
	assign last_col = col_q == CW'(COLUMN_COUNT - 1);
	assign fill     = (int'(held_q) > ksf_pkg::FILL_MAX) ?
		ksf_pkg::FILL_W'(ksf_pkg::FILL_MAX) : ksf_pkg::FILL_W'(held_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ksf_pkg::ST_IDLE: begin
				if (accept) begin
					if (in_req == ksf_pkg::REQ_READ) begin
						state_d = (n_rd == '0) ? ksf_pkg::ST_EMPTY : ksf_pkg::ST_RD_ADDR;
					end else begin
						state_d = row_ok ? ksf_pkg::ST_SCAN : ksf_pkg::ST_SCAN_DONE;
					end
				end
			end
			ksf_pkg::ST_SCAN: begin
				if (last_col) begin
					state_d = ksf_pkg::ST_SCAN_DONE;
				end
			end
			ksf_pkg::ST_SCAN_DONE, ksf_pkg::ST_EMPTY: begin
				if (out_free) begin
					state_d = ksf_pkg::ST_IDLE;
				end
			end
			ksf_pkg::ST_RD_ADDR: begin
				state_d = ksf_pkg::ST_RD_DATA;
			end
			ksf_pkg::ST_RD_DATA: begin
				if (out_free) begin
					state_d = (remain_q == '0) ? ksf_pkg::ST_IDLE : ksf_pkg::ST_RD_ADDR;
				end
			end
			default: state_d = ksf_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready       = 1'b0;
		push           = 1'b0;
		mem_we         = 1'b0;
		mem_re         = 1'b0;
		res.key_char   = 8'h00;
		res.char_valid = 1'b0;
		res.last_item  = 1'b1;
		res.keys_added = 2'd0;
		res.overflow   = 1'b0;
		res.fill_level = fill;
		unique case (state_q)
			ksf_pkg::ST_IDLE: begin
				in_ready = 1'b1;
			end
			ksf_pkg::ST_SCAN: begin
				mem_we = rise && room;
			end
			ksf_pkg::ST_SCAN_DONE: begin
				push           = out_free;
				res.keys_added = added_q;
				res.overflow   = ovf_q;
			end
			ksf_pkg::ST_EMPTY: begin
				push = out_free;
			end
			ksf_pkg::ST_RD_ADDR: begin
				mem_re = 1'b1;
			end
			ksf_pkg::ST_RD_DATA: begin
				push           = out_free;
				res.key_char   = mem_rdata;
				res.char_valid = 1'b1;
				res.last_item  = remain_q == '0;
			end
			default: begin
			end
		endcase
	end

	assign mem_waddr = wr_q;
	assign mem_wdata = ksf_pkg::key_code(row_q, col_q);
	assign mem_raddr = rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ksf_pkg::ST_IDLE;
			key_q    <= '0;
			wr_q     <= '0;
			rd_q     <= '0;
			held_q   <= '0;
			added_q  <= '0;
			ovf_q    <= 1'b0;
			remain_q <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ksf_pkg::ST_IDLE: begin
					if (accept) begin
						added_q  <= '0;
						ovf_q    <= 1'b0;
						remain_q <= n_rd;
					end
				end
				ksf_pkg::ST_SCAN: begin
					if (chg) begin
						key_q[idx_q] <= lvl;
					end
					if (rise) begin
						if (room) begin
							wr_q   <= (int'(wr_q) == RING_DEPTH - 1) ? '0 : wr_q + 1'b1;
							held_q <= held_q + 1'b1;
							if (added_q != 2'd3) begin
								added_q <= added_q + 1'b1;
							end
						end else begin
							ovf_q <= 1'b1;
						end
					end
				end
				ksf_pkg::ST_RD_ADDR: begin
					rd_q     <= (int'(rd_q) == RING_DEPTH - 1) ? '0 : rd_q + 1'b1;
					held_q   <= held_q - 1'b1;
					remain_q <= remain_q - 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// scan operands and column walk
	always_ff @(posedge clk) begin
		if (accept) begin
			row_q <= in_row;
			lvl_q <= in_cols;
			col_q <= '0;
			idx_q <= KW'(int'(in_row) * COLUMN_COUNT);
		end else if (state_q == ksf_pkg::ST_SCAN) begin
			col_q <= col_q + 1'b1;
			idx_q <= idx_q + 1'b1;
		end
	end

endmodule

[sv/keypad_scan_key_fifo.sv]
// Keypad matrix scanner with a character FIFO ring: top level.
// Scan beat: walks the columns in turn, then stages the result in the output beat register.
// Read beat: each drained character passes the ring read port, then the output register, plus stalls.
// Empty read: a single result once the output register is free. Next beat is taken once the result is staged.
// arst_n clears key levels, ring pointers and fill count at once; ring contents are not cleared.
module keypad_scan_key_fifo #(
	parameter int RING_DEPTH = 256,
	parameter int ROW_COUNT = 4,
	parameter int COLUMN_COUNT = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // row_index[1:0], column_levels[4:2], read_limit[11:5]
	input  logic [0:0]  s_tuser,  // req_type[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // key_char[7:0], keys_added[9:8], overflow[10], fill_level[19:11]
	output logic [0:0]  m_tuser,  // char_valid[0]
	output logic        m_tlast
);

	localparam int AW = $clog2(RING_DEPTH);

	logic              push;
	logic              out_free;
	ksf_pkg::ksf_res_t res;
	ksf_pkg::ksf_res_t res_q;
	logic              m_tvalid_q;

	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [7:0]        mem_wdata;
	logic              mem_re;
	logic [AW-1:0]     mem_raddr;
	logic [7:0]        mem_rdata;

	assign out_free = !m_tvalid_q || m_tready;

	ksf_seq #(
		.RING_DEPTH(RING_DEPTH),
		.ROW_COUNT(ROW_COUNT),
		.COLUMN_COUNT(COLUMN_COUNT),
		.AW(AW)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.in_req(s_tuser[0]),
		.in_row(s_tdata[1:0]),
		.in_cols(s_tdata[4:2]),
		.in_limit(s_tdata[11:5]),
		.out_free(out_free),
		.push(push),
		.res(res),
		.mem_we(mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_re(mem_re),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	ksf_ring #(
		.DEPTH(RING_DEPTH),
		.AW(AW)
	) u_ring (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re(mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// output beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (push) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {4'd0, res_q.fill_level, res_q.overflow, res_q.keys_added,
		res_q.key_char};
	assign m_tuser  = res_q.char_valid;
	assign m_tlast  = res_q.last_item;

`include "keypad_scan_key_fifo_assert.svh"

	`KSF_ASSERT_IMP(a_push_room, clk, arst_n, push, out_free, "beat staged over a pending one")
	`KSF_ASSERT_IMP(a_char_clean, clk, arst_n, m_tvalid && m_tuser[0], m_tdata[10:8] == 3'd0, "char beat carries scan flags")
	`KSF_ASSERT_IMP(a_invalid_last, clk, arst_n, m_tvalid && !m_tuser[0], m_tlast, "invalid beat not last")
	`KSF_ASSERT_NEVER(a_fill_bound, clk, arst_n, m_tvalid && (int'(m_tdata[19:11]) > RING_DEPTH), "fill above ring depth")

endmodule

[bench/keypad_tb_pkg.sv]
// Expected-result tracker for the keypad scanner bench: key levels, char ring, result queue.
package keypad_tb_pkg;
	import ksf_pkg::*;

	localparam int RING_SLOTS = 256;
	localparam int READ_CAP = 64;

	class key_fifo_model;
		logic key_level [12];
		logic [7:0] char_ring [RING_SLOTS];
		logic [7:0] wr_slot;
		logic [7:0] rd_slot;
		int held;
		ksf_res_t pending_results [$];
		int mismatches;
		logic [7:0] key_chars [12];

		function new();
			key_chars = '{"1", "2", "3", "4", "5", "6", "7", "8", "9", "*", "0", "#"};
			foreach (key_level[i]) key_level[i] = 1'b0;
			wr_slot = '0;
			rd_slot = '0;
			held = 0;
			mismatches = 0;
		endfunction

		function void push_result(logic [7:0] ch, logic valid, logic last,
			logic [1:0] added, logic ovf);
			ksf_res_t r;
			r.key_char = ch;
			r.char_valid = valid;
			r.last_item = last;
			r.keys_added = added;
			r.overflow = ovf;
			r.fill_level = (held > FILL_MAX) ? FILL_W'(FILL_MAX) : FILL_W'(held);
			pending_results.push_back(r);
		endfunction

		// accepted input beat: advance the state and queue what it should produce
		function void take_item(logic req, logic [1:0] row, logic [2:0] cols,
			logic [6:0] limit);
			int idx;
			int lim;
			int n;
			logic [1:0] added;
			logic ovf;
			added = '0;
			ovf = 1'b0;
			if (req == REQ_SCAN) begin
				for (int c = 0; c < 3; c++) begin
					idx = int'(row) * 3 + c;
					if (key_level[idx] != cols[c]) begin
						key_level[idx] = cols[c];
						if (cols[c]) begin
							if (held < RING_SLOTS) begin
								char_ring[wr_slot] = key_chars[idx];
								wr_slot = wr_slot + 8'd1;
								held++;
								if (added != 2'd3) added = added + 2'd1;
							end else begin
								ovf = 1'b1;
							end
						end
					end
				end
				push_result(8'h00, 1'b0, 1'b1, added, ovf);
			end else begin
				lim = (int'(limit) > READ_CAP) ? READ_CAP : int'(limit);
				n = (held < lim) ? held : lim;
				if (n == 0) begin
					push_result(8'h00, 1'b0, 1'b1, 2'd0, 1'b0);
				end else begin
					for (int i = 0; i < n; i++) begin
						idx = int'(rd_slot);
						rd_slot = rd_slot + 8'd1;
						held--;
						push_result(char_ring[idx], 1'b1, (i == n - 1), 2'd0, 1'b0);
					end
				end
			end
		endfunction

		function void field_cmp(string name, int exp_v, int act_v);
			if (exp_v != act_v) begin
				$error("%s: expected %0d, actual %0d", name, exp_v, act_v);
				mismatches++;
			end
		endfunction

		function void match_result(ksf_res_t got);
			ksf_res_t exp_r;
			if (pending_results.size() == 0) begin
				$error("result beat with nothing pending: key_char %0d fill_level %0d",
					got.key_char, got.fill_level);
				mismatches++;
				return;
			end
			exp_r = pending_results.pop_front();
			field_cmp("key_char", exp_r.key_char, got.key_char);
			field_cmp("char_valid", exp_r.char_valid, got.char_valid);
			field_cmp("last_item", exp_r.last_item, got.last_item);
			field_cmp("keys_added", exp_r.keys_added, got.keys_added);
			field_cmp("overflow", exp_r.overflow, got.overflow);
			field_cmp("fill_level", exp_r.fill_level, got.fill_level);
		endfunction

		function int outstanding();
			return pending_results.size();
		endfunction
	endclass

endpackage

[bench/testbench.sv]
// Top-level bench for the keypad scanner with key FIFO: stimulus, handshakes and checking.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ksf_pkg::*;
	import keypad_tb_pkg::*;

	logic clk = 1'b0;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [15:0] s_tdata;  // row_index[1:0], column_levels[4:2], read_limit[11:5]
	logic [0:0] s_tuser;   // req_type[0]
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [23:0] m_tdata;  // key_char[7:0], keys_added[9:8], overflow[10], fill_level[19:11]
	logic [0:0] m_tuser;   // char_valid[0]
	logic m_tlast;

	int src_idle = 8;
	int sink_idle = 57;
	logic [2:0] sent_levels [4] = '{3'b000, 3'b000, 3'b000, 3'b000};
	key_fifo_model fifo_model = new();

	keypad_scan_key_fifo dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// receiver side: random stalls, a check of every accepted result beat, and model update for accepted input beats
	always @(posedge clk) begin
		ksf_res_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.key_char = m_tdata[7:0];
			got.keys_added = m_tdata[9:8];
			got.overflow = m_tdata[10];
			got.fill_level = m_tdata[19:11];
			got.char_valid = m_tuser[0];
			got.last_item = m_tlast;
			fifo_model.match_result(got);
		end
		if (arst_n && s_tvalid && s_tready) begin
			fifo_model.take_item(s_tuser[0], s_tdata[1:0], s_tdata[4:2], s_tdata[11:5]);
		end
		m_tready <= (arst_n && $urandom_range(99) >= sink_idle);
	end

	task automatic send_beat(input logic req, input logic [1:0] row,
		input logic [2:0] cols, input logic [6:0] limit);
		while ($urandom_range(99) < src_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= req;
		s_tdata <= {4'b0000, limit, cols, row};
		if (req == REQ_SCAN) sent_levels[row] = cols;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	function automatic logic [6:0] pick_limit(input int max_lim);
		int r;
		r = $urandom_range(99);
		if (max_lim < READ_CAP) return 7'($urandom_range(max_lim, 1));
		if (r < 8) return 7'd0;
		if (r < 16) return 7'($urandom_range(127, 65));
		if (r < 46) return 7'($urandom_range(64, 1));
		return 7'($urandom_range(8, 1));
	endfunction

	// fill_pct: share of scans that toggle a row between released and pressed
	task automatic random_items(input int count, input int read_pct, input int fill_pct,
		input int max_lim);
		logic [1:0] row;
		logic [2:0] cols;
		for (int i = 0; i < count; i++) begin
			row = 2'($urandom_range(3));
			if ($urandom_range(99) < read_pct) begin
				send_beat(REQ_READ, row, 3'($urandom_range(7)), pick_limit(max_lim));
			end else begin
				if ($urandom_range(99) < fill_pct) begin
					if (sent_levels[row] != 3'b000) cols = 3'b000;
					else if ($urandom_range(3) == 0) cols = 3'($urandom_range(7, 1));
					else cols = 3'b111;
				end else begin
					cols = 3'($urandom_range(7));
				end
				send_beat(REQ_SCAN, row, cols, 7'($urandom_range(127)));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty reads, every key, no-change scan, zero and clamped limits
		send_beat(REQ_READ, 2'd0, 3'b000, 7'd1);
		send_beat(REQ_READ, 2'd3, 3'b111, 7'd0);
		for (int r = 0; r < 4; r++) send_beat(REQ_SCAN, 2'(r), 3'b111, 7'd0);
		send_beat(REQ_SCAN, 2'd2, 3'b111, 7'd127);
		send_beat(REQ_SCAN, 2'd0, 3'b000, 7'd0);
		send_beat(REQ_READ, 2'd0, 3'b000, 7'd0);
		send_beat(REQ_READ, 2'd1, 3'b010, 7'd5);
		send_beat(REQ_READ, 2'd2, 3'b101, 7'd127);
		send_beat(REQ_READ, 2'd0, 3'b000, 7'd64);
		send_beat(REQ_SCAN, 2'd1, 3'b010, 7'd0);
		send_beat(REQ_SCAN, 2'd1, 3'b101, 7'd0);
		send_beat(REQ_SCAN, 2'd0, 3'b001, 7'd0);
		send_beat(REQ_SCAN, 2'd2, 3'b000, 7'd0);
		send_beat(REQ_SCAN, 2'd3, 3'b000, 7'd0);
		send_beat(REQ_READ, 2'd3, 3'b111, 7'd64);
		send_beat(REQ_SCAN, 2'd0, 3'b000, 7'd127);

		// fill the ring well past full so keys get dropped, then drain and mix
		random_items(250, 3, 95, 3);
		src_idle = 57;
		sink_idle = 8;
		random_items(110, 45, 50, READ_CAP);
		src_idle = 0;
		sink_idle = 0;
		random_items(110, 30, 60, READ_CAP);
		s_tvalid <= 1'b0;
		// let the monitor log the last accepted beat before polling the queue
		@(posedge clk);

		while (fifo_model.outstanding() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		if (fifo_model.mismatches == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("testbench: errors");
		$finish;
	end

endmodule
